### src/dnsrp_pkg.sv
package dnsrp_pkg;

    localparam int BUF_BYTES  = 512;
    localparam int NAME_CHARS = 63;
    localparam int MAX_HOPS   = 256;

    localparam int BUF_AW  = $clog2(BUF_BYTES);
    localparam int CNT_W   = $clog2(BUF_BYTES + 1);
    localparam int NAME_AW = $clog2(NAME_CHARS);
    localparam int NPOS_W  = $clog2(NAME_CHARS + 1);
    localparam int HOP_W   = $clog2(MAX_HOPS + 1);
    localparam int OFF_W   = 18;
    localparam int SH_W    = 80;

    localparam int HDR_LEN  = 12;
    localparam int HDR_BYTES = 8;
    localparam int RR_BYTES  = 10;
    localparam int A_BYTES   = 4;

    localparam logic [15:0] TYPE_A     = 16'd1;
    localparam logic [15:0] TYPE_CNAME = 16'd5;
    localparam logic [15:0] TYPE_PTR   = 16'd12;
    localparam logic [15:0] CLASS_IN   = 16'd1;
    localparam logic [7:0]  PTR_MASK   = 8'hC0;
    localparam logic [7:0]  CHAR_DOT   = 8'h2E;

    typedef enum logic [2:0] {
        ST_ADDR     = 3'd0,
        ST_NAME     = 3'd1,
        ST_NOT_RESP = 3'd2,
        ST_ID_MISS  = 3'd3,
        ST_RCODE    = 3'd4,
        ST_NO_ANS   = 3'd5,
        ST_NO_MATCH = 3'd6,
        ST_SHORT    = 3'd7
    } t_status;

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_CHK  = 14'b00000000000010,
        S_GET  = 14'b00000000000100,
        S_HCHK = 14'b00000000001000,
        S_QD   = 14'b00000000010000,
        S_AN   = 14'b00000000100000,
        S_SKN  = 14'b00000001000000,
        S_SKP  = 14'b00000010000000,
        S_RCHK = 14'b00000100000000,
        S_AOUT = 14'b00001000000000,
        S_DN   = 14'b00010000000000,
        S_DNP  = 14'b00100000000000,
        S_DL   = 14'b01000000000000,
        S_NM   = 14'b10000000000000
    } t_state;

endpackage

### src/dnsrp_ram.sv
module dnsrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/dns_response_parser.sv
// DNS response parser. Pulse start with i_action=1 to arm a query id, then feed the
// response one byte per cycle (start high, busy low) with i_last_byte on the final
// byte; bytes past the 512-byte packet memory are dropped. After the last byte busy
// stays high while the parse runs: each packet byte read takes an address step and
// then a registered-data step on the single read port of the packet memory. One
// status transaction follows, and for a PTR answer one transaction per name
// character. o_valid marks each transaction for exactly one cycle and cannot be
// held off; o_last_item flags the final one of a packet.
module dns_response_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_action,
    input  logic [7:0]  i_packet_byte,
    input  logic [15:0] i_query_id,
    input  logic        i_last_byte,
    output logic        o_valid,
    output logic        o_item_kind,
    output logic [2:0]  o_status,
    output logic [3:0]  o_rcode,
    output logic [31:0] o_address,
    output logic [31:0] o_ttl,
    output logic        o_has_alias,
    output logic [7:0]  o_name_char,
    output logic        o_last_item
);

    localparam int OW = dnsrp_pkg::OFF_W;

    dnsrp_pkg::t_state r_state, n_state, r_nxt, n_nxt;
    logic                          r_wait, n_wait;
    logic [dnsrp_pkg::CNT_W-1:0]   r_cnt, n_cnt, r_plen, n_plen;
    logic [15:0]                   r_exp_id, n_exp_id;
    logic                          r_alias, n_alias;
    logic                          r_rv;
    logic [3:0]                    r_idx, n_idx, r_glen, n_glen;
    logic [OW-1:0]                 r_gbase, n_gbase, r_off, n_off, r_jend, n_jend;
    logic [dnsrp_pkg::SH_W-1:0]    r_sh, n_sh;
    logic [15:0]                   r_n, n_n;
    logic                          r_in_an, n_in_an, r_jmp, n_jmp, r_ldot, n_ldot;
    logic [dnsrp_pkg::HOP_W-1:0]   r_hops, n_hops;
    logic [5:0]                    r_b, n_b;
    logic [dnsrp_pkg::NPOS_W-1:0]  r_pos, n_pos, r_nlen, n_nlen, r_c, n_c;
    logic [7:0]                    r_k, n_k;
    logic [3:0]                    r_rcode, n_rcode;
    logic [31:0]                   r_ttl, n_ttl;

    logic                          r_valid, n_valid;
    logic                          r_kind, n_kind;
    dnsrp_pkg::t_status            r_status, n_status;
    logic [3:0]                    r_rc_o, n_rc_o;
    logic [31:0]                   r_addr_o, n_addr_o, r_ttl_o, n_ttl_o;
    logic                          r_alias_o, n_alias_o, r_last, n_last;
    logic [7:0]                    r_char, n_char;

    logic                          em, em_kind, em_last;
    dnsrp_pkg::t_status            em_status;
    logic [3:0]                    em_rcode;
    logic [31:0]                   em_addr, em_ttl;
    logic [7:0]                    em_char;

    logic                          sk_done, dn_done;
    logic [OW-1:0]                 sk_res, rd_addr, rr_end;
    logic [dnsrp_pkg::NPOS_W-1:0]  dn_len;

    logic                          pk_we, nm_we;
    logic [dnsrp_pkg::BUF_AW-1:0]  pk_wa;
    logic [7:0]                    pk_q, nm_q, nm_wd, rb;
    logic [dnsrp_pkg::NAME_AW-1:0] nm_wa, nm_ra;
    logic [15:0]                   rr_type, rr_cls, rr_len;

    logic                          walk_ok, dn_walk_ok;

    dnsrp_ram #(.WIDTH(8), .DEPTH(dnsrp_pkg::BUF_BYTES)) u_pkt (
        .i_clk   (i_clk),
        .i_we    (pk_we),
        .i_waddr (pk_wa),
        .i_wdata (i_packet_byte),
        .i_raddr (rd_addr[dnsrp_pkg::BUF_AW-1:0]),
        .o_rdata (pk_q)
    );

    dnsrp_ram #(.WIDTH(8), .DEPTH(dnsrp_pkg::NAME_CHARS)) u_name (
        .i_clk   (i_clk),
        .i_we    (nm_we),
        .i_waddr (nm_wa),
        .i_wdata (nm_wd),
        .i_raddr (nm_ra),
        .o_rdata (nm_q)
    );

    assign rb      = r_rv ? pk_q : 8'h00;
    assign rr_type = r_sh[79:64];
    assign rr_cls  = r_sh[63:48];
    assign rr_len  = r_sh[15:0];
    assign rr_end  = r_off + OW'(dnsrp_pkg::RR_BYTES);
    assign walk_ok = (r_off < OW'(r_plen)) &&
                     (r_hops < dnsrp_pkg::HOP_W'(dnsrp_pkg::MAX_HOPS));
    assign dn_walk_ok = walk_ok;

    always_comb begin
        n_state = r_state;   n_nxt = r_nxt;     n_wait = r_wait;
        n_cnt = r_cnt;       n_plen = r_plen;   n_exp_id = r_exp_id;
        n_alias = r_alias;   n_idx = r_idx;     n_glen = r_glen;
        n_gbase = r_gbase;   n_off = r_off;     n_jend = r_jend;
        n_sh = r_sh;         n_n = r_n;         n_in_an = r_in_an;
        n_jmp = r_jmp;       n_ldot = r_ldot;   n_hops = r_hops;
        n_b = r_b;           n_pos = r_pos;     n_nlen = r_nlen;
        n_c = r_c;           n_k = r_k;         n_rcode = r_rcode;
        n_ttl = r_ttl;
        n_valid = 1'b0;      n_kind = r_kind;   n_status = r_status;
        n_rc_o = r_rc_o;     n_addr_o = r_addr_o; n_ttl_o = r_ttl_o;
        n_alias_o = r_alias_o; n_last = r_last; n_char = r_char;

        em = 1'b0;           em_kind = 1'b0;    em_last = 1'b1;
        em_status = dnsrp_pkg::ST_NO_MATCH;
        em_rcode = r_rcode;  em_addr = '0;      em_ttl = '0;  em_char = '0;
        sk_done = 1'b0;      sk_res = r_off;
        dn_done = 1'b0;      dn_len = r_pos;

        pk_we = 1'b0;        pk_wa = r_cnt[dnsrp_pkg::BUF_AW-1:0];
        nm_we = 1'b0;        nm_wa = r_pos[dnsrp_pkg::NAME_AW-1:0];
        nm_wd = rb;          nm_ra = r_c[dnsrp_pkg::NAME_AW-1:0];
        rd_addr = r_off;

        case (r_state)
            dnsrp_pkg::S_IDLE: begin
                if (start) begin
                    if (i_action) begin
                        n_exp_id = i_query_id;
                        n_alias  = 1'b0;
                        n_cnt    = '0;
                    end else begin
                        if (r_cnt < dnsrp_pkg::CNT_W'(dnsrp_pkg::BUF_BYTES)) begin
                            pk_we = 1'b1;
                            n_cnt = r_cnt + 1'b1;
                        end
                        if (i_last_byte) begin
                            n_plen  = n_cnt;
                            n_state = dnsrp_pkg::S_CHK;
                        end
                    end
                end
            end
            dnsrp_pkg::S_CHK: begin
                n_cnt = '0;
                if (r_plen < dnsrp_pkg::CNT_W'(dnsrp_pkg::HDR_LEN)) begin
                    em        = 1'b1;
                    em_status = dnsrp_pkg::ST_SHORT;
                    em_rcode  = 4'd0;
                    n_state   = dnsrp_pkg::S_IDLE;
                end else begin
                    n_gbase = '0;
                    n_glen  = 4'(dnsrp_pkg::HDR_BYTES);
                    n_idx   = '0;
                    n_wait  = 1'b0;
                    n_nxt   = dnsrp_pkg::S_HCHK;
                    n_state = dnsrp_pkg::S_GET;
                end
            end
            dnsrp_pkg::S_GET: begin
                rd_addr = r_gbase + OW'(r_idx);
                if (!r_wait) begin
                    if (r_idx == r_glen) begin
                        n_state = r_nxt;
                    end else begin
                        n_wait = 1'b1;
                    end
                end else begin
                    n_sh   = {r_sh[dnsrp_pkg::SH_W-9:0], rb};
                    n_idx  = r_idx + 1'b1;
                    n_wait = 1'b0;
                end
            end
            dnsrp_pkg::S_HCHK: begin
                n_rcode  = r_sh[35:32];
                em_rcode = r_sh[35:32];
                if (!r_sh[47]) begin
                    em = 1'b1;  em_status = dnsrp_pkg::ST_NOT_RESP;
                    n_state = dnsrp_pkg::S_IDLE;
                end else if (r_sh[63:48] != r_exp_id) begin
                    em = 1'b1;  em_status = dnsrp_pkg::ST_ID_MISS;
                    n_state = dnsrp_pkg::S_IDLE;
                end else if (r_sh[35:32] != 4'd0) begin
                    em = 1'b1;  em_status = dnsrp_pkg::ST_RCODE;
                    n_state = dnsrp_pkg::S_IDLE;
                end else if (r_sh[15:0] == 16'd0) begin
                    em = 1'b1;  em_status = dnsrp_pkg::ST_NO_ANS;
                    n_state = dnsrp_pkg::S_IDLE;
                end else begin
                    n_off   = OW'(dnsrp_pkg::HDR_LEN);
                    n_n     = r_sh[31:16];
                    n_state = dnsrp_pkg::S_QD;
                end
            end
            dnsrp_pkg::S_QD: begin
                if (r_n != 16'd0 && r_off < OW'(r_plen)) begin
                    n_n = r_n - 1'b1;  n_hops = '0;  n_jmp = 1'b0;
                    n_in_an = 1'b0;    n_wait = 1'b0;
                    n_state = dnsrp_pkg::S_SKN;
                end else begin
                    n_n     = r_sh[15:0];
                    n_state = dnsrp_pkg::S_AN;
                end
            end
            dnsrp_pkg::S_AN: begin
                if (r_n != 16'd0 && r_off < OW'(r_plen)) begin
                    n_n = r_n - 1'b1;  n_hops = '0;  n_jmp = 1'b0;
                    n_in_an = 1'b1;    n_wait = 1'b0;
                    n_state = dnsrp_pkg::S_SKN;
                end else begin
                    em = 1'b1;  em_status = dnsrp_pkg::ST_NO_MATCH;
                    n_state = dnsrp_pkg::S_IDLE;
                end
            end
            dnsrp_pkg::S_SKN: begin
                if (!r_wait) begin
                    if (walk_ok) begin
                        n_wait = 1'b1;
                    end else begin
                        sk_done = 1'b1;
                        sk_res  = r_jmp ? r_jend : r_off;
                    end
                end else begin
                    n_wait = 1'b0;
                    if (rb == 8'h00) begin
                        sk_done = 1'b1;
                        sk_res  = r_jmp ? r_jend : r_off + OW'(1);
                    end else if ((rb & dnsrp_pkg::PTR_MASK) == dnsrp_pkg::PTR_MASK) begin
                        n_b     = rb[5:0];
                        n_state = dnsrp_pkg::S_SKP;
                    end else begin
                        n_off  = r_off + OW'(rb) + OW'(1);
                        n_hops = r_hops + 1'b1;
                    end
                end
            end
            dnsrp_pkg::S_SKP: begin
                rd_addr = r_off + OW'(1);
                if (!r_wait) begin
                    n_wait = 1'b1;
                end else begin
                    n_wait = 1'b0;
                    if (!r_jmp) begin
                        n_jmp  = 1'b1;
                        n_jend = r_off + OW'(2);
                    end
                    n_off   = OW'({r_b, rb});
                    n_hops  = r_hops + 1'b1;
                    n_state = dnsrp_pkg::S_SKN;
                end
            end
            dnsrp_pkg::S_RCHK: begin
                if (rr_end + OW'(rr_len) > OW'(r_plen)) begin
                    em = 1'b1;  em_status = dnsrp_pkg::ST_NO_MATCH;
                    n_state = dnsrp_pkg::S_IDLE;
                end else if (rr_type == dnsrp_pkg::TYPE_A && rr_cls == dnsrp_pkg::CLASS_IN
                             && rr_len == 16'd4) begin
                    n_ttl   = r_sh[47:16];
                    n_gbase = rr_end;
                    n_glen  = 4'(dnsrp_pkg::A_BYTES);
                    n_idx   = '0;
                    n_wait  = 1'b0;
                    n_nxt   = dnsrp_pkg::S_AOUT;
                    n_state = dnsrp_pkg::S_GET;
                end else if (rr_type == dnsrp_pkg::TYPE_PTR
                             && rr_cls == dnsrp_pkg::CLASS_IN) begin
                    n_ttl   = r_sh[47:16];
                    n_off   = rr_end;
                    n_pos   = '0;
                    n_hops  = '0;
                    n_ldot  = 1'b0;
                    n_wait  = 1'b0;
                    n_state = dnsrp_pkg::S_DN;
                end else begin
                    if (rr_type == dnsrp_pkg::TYPE_CNAME && rr_cls == dnsrp_pkg::CLASS_IN) begin
                        n_alias = 1'b1;
                    end
                    n_off   = rr_end + OW'(rr_len);
                    n_state = dnsrp_pkg::S_AN;
                end
            end
            dnsrp_pkg::S_AOUT: begin
                em = 1'b1;  em_status = dnsrp_pkg::ST_ADDR;
                em_addr = r_sh[31:0];
                em_ttl  = r_ttl;
                n_state = dnsrp_pkg::S_IDLE;
            end
            dnsrp_pkg::S_DN: begin
                if (!r_wait) begin
                    if (dn_walk_ok) begin
                        n_wait = 1'b1;
                    end else begin
                        dn_done = 1'b1;
                    end
                end else begin
                    n_wait = 1'b0;
                    if (rb == 8'h00) begin
                        dn_done = 1'b1;
                        if (r_pos != '0 && r_ldot) begin
                            dn_len = r_pos - 1'b1;
                        end
                    end else if ((rb & dnsrp_pkg::PTR_MASK) == dnsrp_pkg::PTR_MASK) begin
                        n_b     = rb[5:0];
                        n_state = dnsrp_pkg::S_DNP;
                    end else begin
                        n_off   = r_off + OW'(1);
                        n_k     = rb;
                        n_state = dnsrp_pkg::S_DL;
                    end
                end
            end
            dnsrp_pkg::S_DNP: begin
                rd_addr = r_off + OW'(1);
                if (!r_wait) begin
                    n_wait = 1'b1;
                end else begin
                    n_wait  = 1'b0;
                    n_off   = OW'({r_b, rb});
                    n_hops  = r_hops + 1'b1;
                    n_state = dnsrp_pkg::S_DN;
                end
            end
            dnsrp_pkg::S_DL: begin
                if (!r_wait) begin
                    if (r_k == 8'd0) begin
                        if (r_pos < dnsrp_pkg::NPOS_W'(dnsrp_pkg::NAME_CHARS)) begin
                            nm_we  = 1'b1;
                            nm_wd  = dnsrp_pkg::CHAR_DOT;
                            n_pos  = r_pos + 1'b1;
                            n_ldot = 1'b1;
                        end else begin
                            n_ldot = 1'b0;
                        end
                        n_hops  = r_hops + 1'b1;
                        n_state = dnsrp_pkg::S_DN;
                    end else if (({1'b0, r_pos} + 1'b1)
                                 >= (dnsrp_pkg::NPOS_W + 1)'(dnsrp_pkg::NAME_CHARS)) begin
                        n_off = r_off + OW'(r_k);
                        n_k   = 8'd0;
                    end else begin
                        n_wait = 1'b1;
                    end
                end else begin
                    n_wait = 1'b0;
                    nm_we  = 1'b1;
                    n_pos  = r_pos + 1'b1;
                    n_ldot = 1'b0;
                    n_off  = r_off + OW'(1);
                    n_k    = r_k - 1'b1;
                end
            end
            dnsrp_pkg::S_NM: begin
                if (!r_wait) begin
                    n_wait = 1'b1;
                end else begin
                    n_wait  = 1'b0;
                    em      = 1'b1;
                    em_kind = 1'b1;
                    em_char = nm_q;
                    em_last = ((r_c + 1'b1) == r_nlen);
                    n_c     = r_c + 1'b1;
                    if (em_last) begin
                        n_state = dnsrp_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = dnsrp_pkg::S_IDLE;
            end
        endcase

        if (sk_done) begin
            if (r_in_an) begin
                n_off = sk_res;
                if (sk_res + OW'(dnsrp_pkg::RR_BYTES) > OW'(r_plen)) begin
                    em = 1'b1;  em_status = dnsrp_pkg::ST_NO_MATCH;
                    n_state = dnsrp_pkg::S_IDLE;
                end else begin
                    n_gbase = sk_res;
                    n_glen  = 4'(dnsrp_pkg::RR_BYTES);
                    n_idx   = '0;
                    n_wait  = 1'b0;
                    n_nxt   = dnsrp_pkg::S_RCHK;
                    n_state = dnsrp_pkg::S_GET;
                end
            end else begin
                n_off   = sk_res + OW'(4);
                n_state = dnsrp_pkg::S_QD;
            end
        end

        if (dn_done) begin
            n_nlen    = dn_len;
            n_c       = '0;
            n_wait    = 1'b0;
            em        = 1'b1;
            em_status = dnsrp_pkg::ST_NAME;
            em_ttl    = r_ttl;
            em_last   = (dn_len == '0);
            n_state   = (dn_len == '0) ? dnsrp_pkg::S_IDLE : dnsrp_pkg::S_NM;
        end

        if (em) begin
            n_valid   = 1'b1;
            n_kind    = em_kind;
            n_status  = em_kind ? dnsrp_pkg::ST_ADDR : em_status;
            n_rc_o    = em_kind ? 4'd0 : em_rcode;
            n_addr_o  = em_addr;
            n_ttl_o   = em_ttl;
            n_alias_o = em_kind ? 1'b0 : n_alias;
            n_char    = em_char;
            n_last    = em_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dnsrp_pkg::S_IDLE;
            r_wait   <= 1'b0;
            r_cnt    <= '0;
            r_plen   <= '0;
            r_exp_id <= '0;
            r_alias  <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wait   <= n_wait;
            r_cnt    <= n_cnt;
            r_plen   <= n_plen;
            r_exp_id <= n_exp_id;
            r_alias  <= n_alias;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rv      <= rd_addr < OW'(r_plen);
        r_nxt     <= n_nxt;
        r_idx     <= n_idx;
        r_glen    <= n_glen;
        r_gbase   <= n_gbase;
        r_off     <= n_off;
        r_jend    <= n_jend;
        r_sh      <= n_sh;
        r_n       <= n_n;
        r_in_an   <= n_in_an;
        r_jmp     <= n_jmp;
        r_ldot    <= n_ldot;
        r_hops    <= n_hops;
        r_b       <= n_b;
        r_pos     <= n_pos;
        r_nlen    <= n_nlen;
        r_c       <= n_c;
        r_k       <= n_k;
        r_rcode   <= n_rcode;
        r_ttl     <= n_ttl;
        r_kind    <= n_kind;
        r_status  <= n_status;
        r_rc_o    <= n_rc_o;
        r_addr_o  <= n_addr_o;
        r_ttl_o   <= n_ttl_o;
        r_alias_o <= n_alias_o;
        r_last    <= n_last;
        r_char    <= n_char;
    end

    assign busy        = (r_state != dnsrp_pkg::S_IDLE);
    assign o_valid     = r_valid;
    assign o_item_kind = r_kind;
    assign o_status    = r_status;
    assign o_rcode     = r_rc_o;
    assign o_address   = r_addr_o;
    assign o_ttl       = r_ttl_o;
    assign o_has_alias = r_alias_o;
    assign o_name_char = r_char;
    assign o_last_item = r_last;

`ifndef NO_ASSERTIONS
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a parse in progress");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= dnsrp_pkg::CNT_W'(dnsrp_pkg::BUF_BYTES))
        else $error("byte count past buffer size");

    a_char_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item_kind) |-> (o_status == dnsrp_pkg::ST_ADDR && o_ttl == 32'd0
                                      && o_address == 32'd0))
        else $error("name character carries status fields");

    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_action && i_last_byte) |=> busy)
        else $error("last byte did not start a parse");
`endif

endmodule

### tb/tb_dns_response_parser.sv
`timescale 1ns / 100ps

module tb_dns_response_parser;

    typedef logic [7:0] t_u8;

    typedef struct packed {
        logic        kind;
        logic [2:0]  status;
        logic [3:0]  rcode;
        logic [31:0] addr;
        logic [31:0] ttl;
        logic        alias_f;
        logic [7:0]  ch;
        logic        last;
    } t_answer;

    localparam int WATCHDOG_CYCLES = 500000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_action = 1'b0;
    logic [7:0]  i_packet_byte = 8'd0;
    logic [15:0] i_query_id = 16'd0;
    logic        i_last_byte = 1'b0;
    logic        o_valid;
    logic        o_item_kind;
    logic [2:0]  o_status;
    logic [3:0]  o_rcode;
    logic [31:0] o_address;
    logic [31:0] o_ttl;
    logic        o_has_alias;
    logic [7:0]  o_name_char;
    logic        o_last_item;

    dns_response_parser dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // predictor state
    t_u8         pkt_mem [dnsrp_pkg::BUF_BYTES];
    int unsigned rx_count = 0;
    logic [15:0] armed_id = 16'd0;
    logic        cname_seen = 1'b0;
    int unsigned parse_len;
    t_u8         name_q[$];

    t_answer     answers_due[$];
    t_u8         pkt[$];
    int          errors = 0;
    int          stall_cycles = 0;
    bit          quiet = 1'b0;

    function automatic int unsigned rd(int unsigned i);
        return (i < parse_len && i < dnsrp_pkg::BUF_BYTES) ? int'(pkt_mem[i]) : 0;
    endfunction

    function automatic int unsigned rd16(int unsigned i);
        return (rd(i) << 8) | rd(i + 1);
    endfunction

    function automatic int unsigned skip_name(int unsigned off);
        bit          jumped = 1'b0;
        int unsigned jump_end = 0;
        int unsigned hops = 0;
        int unsigned b;
        while (off < parse_len && hops < dnsrp_pkg::MAX_HOPS) begin
            b = rd(off);
            if (b == 0) return jumped ? jump_end : off + 1;
            if ((b & 'hC0) == 'hC0) begin
                if (!jumped) begin
                    jumped = 1'b1;
                    jump_end = off + 2;
                end
                off = ((b & 'h3F) << 8) | rd(off + 1);
            end else begin
                off += b + 1;
            end
            hops++;
        end
        return jumped ? jump_end : off;
    endfunction

    function automatic void decode_name(int unsigned off);
        int unsigned hops = 0;
        int unsigned b;
        bit          last_dot = 1'b0;
        name_q.delete();
        while (off < parse_len && hops < dnsrp_pkg::MAX_HOPS) begin
            b = rd(off);
            if (b == 0) begin
                if (name_q.size() > 0 && last_dot) void'(name_q.pop_back());
                return;
            end
            if ((b & 'hC0) == 'hC0) begin
                off = ((b & 'h3F) << 8) | rd(off + 1);
            end else begin
                off++;
                for (int unsigned k = 0; k < b; k++) begin
                    if (name_q.size() + 1 < dnsrp_pkg::NAME_CHARS) begin
                        name_q.push_back(t_u8'(rd(off)));
                        last_dot = 1'b0;
                    end
                    off++;
                end
                if (name_q.size() < dnsrp_pkg::NAME_CHARS) begin
                    name_q.push_back(dnsrp_pkg::CHAR_DOT);
                    last_dot = 1'b1;
                end else begin
                    last_dot = 1'b0;
                end
            end
            hops++;
        end
    endfunction

    function automatic void push_status(dnsrp_pkg::t_status st, int unsigned rc,
                                        logic [31:0] addr, logic [31:0] ttl, logic last);
        t_answer a;
        a = '0;
        a.status = st;
        a.rcode = rc[3:0];
        a.addr = addr;
        a.ttl = ttl;
        a.alias_f = cname_seen;
        a.last = last;
        answers_due.push_back(a);
    endfunction

    function automatic void parse_packet();
        int unsigned flags, rc, qd, an, off, typ, cls, rdlen;
        logic [31:0] ttl;
        t_answer     a;
        parse_len = rx_count;
        if (parse_len < dnsrp_pkg::HDR_LEN) begin
            push_status(dnsrp_pkg::ST_SHORT, 0, 0, 0, 1'b1);
            return;
        end
        flags = rd16(2);
        rc = flags & 'hF;
        qd = rd16(4);
        an = rd16(6);
        if ((flags & 'h8000) == 0) begin
            push_status(dnsrp_pkg::ST_NOT_RESP, rc, 0, 0, 1'b1);
            return;
        end
        if (rd16(0) != armed_id) begin
            push_status(dnsrp_pkg::ST_ID_MISS, rc, 0, 0, 1'b1);
            return;
        end
        if (rc != 0) begin
            push_status(dnsrp_pkg::ST_RCODE, rc, 0, 0, 1'b1);
            return;
        end
        if (an == 0) begin
            push_status(dnsrp_pkg::ST_NO_ANS, rc, 0, 0, 1'b1);
            return;
        end
        off = dnsrp_pkg::HDR_LEN;
        for (int unsigned i = 0; i < qd && off < parse_len; i++) off = skip_name(off) + 4;
        for (int unsigned i = 0; i < an && off < parse_len; i++) begin
            off = skip_name(off);
            if (off + 10 > parse_len) break;
            typ = rd16(off);
            cls = rd16(off + 2);
            ttl = {t_u8'(rd(off + 4)), t_u8'(rd(off + 5)), t_u8'(rd(off + 6)),
                   t_u8'(rd(off + 7))};
            rdlen = rd16(off + 8);
            off += 10;
            if (off + rdlen > parse_len) break;
            if (typ == dnsrp_pkg::TYPE_A && cls == dnsrp_pkg::CLASS_IN && rdlen == 4) begin
                push_status(dnsrp_pkg::ST_ADDR, rc,
                    {t_u8'(rd(off)), t_u8'(rd(off + 1)), t_u8'(rd(off + 2)),
                     t_u8'(rd(off + 3))},
                    ttl, 1'b1);
                return;
            end
            if (typ == dnsrp_pkg::TYPE_CNAME && cls == dnsrp_pkg::CLASS_IN) cname_seen = 1'b1;
            if (typ == dnsrp_pkg::TYPE_PTR && cls == dnsrp_pkg::CLASS_IN) begin
                decode_name(off);
                push_status(dnsrp_pkg::ST_NAME, rc, 0, ttl, name_q.size() == 0);
                foreach (name_q[c]) begin
                    a = '0;
                    a.kind = 1'b1;
                    a.ch = name_q[c];
                    a.last = (c == name_q.size() - 1);
                    answers_due.push_back(a);
                end
                return;
            end
            off += rdlen;
        end
        push_status(dnsrp_pkg::ST_NO_MATCH, rc, 0, 0, 1'b1);
    endfunction

    function automatic void model_accept(logic act, t_u8 b, logic [15:0] id, logic lst);
        if (act) begin
            armed_id = id;
            cname_seen = 1'b0;
            rx_count = 0;
            return;
        end
        if (rx_count < dnsrp_pkg::BUF_BYTES) begin
            pkt_mem[rx_count] = b;
            rx_count++;
        end
        if (lst) begin
            parse_packet();
            rx_count = 0;
        end
    endfunction

    task automatic idle(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_item(logic act, t_u8 b, logic [15:0] id, logic lst);
        if (!quiet && $urandom_range(0, 9) == 0) idle($urandom_range(1, 14));
        start <= 1'b1;
        i_action <= act;
        i_packet_byte <= b;
        i_query_id <= id;
        i_last_byte <= lst;
        do @(posedge i_clk); while (busy);
        model_accept(act, b, id, lst);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_packet(bit do_arm, logic [15:0] id);
        if (do_arm) send_item(1'b1, t_u8'($urandom), id, 1'($urandom));
        foreach (pkt[i]) send_item(1'b0, pkt[i], 16'($urandom), i == pkt.size() - 1);
    endtask

    // packet builders
    function automatic void put16(int unsigned v);
        pkt.push_back(t_u8'(v >> 8));
        pkt.push_back(t_u8'(v));
    endfunction

    function automatic void put_hdr(logic [15:0] id, logic [15:0] flags, int qd, int an);
        pkt.delete();
        put16(id);
        put16(flags);
        put16(qd);
        put16(an);
        put16($urandom_range(0, 1));
        put16($urandom_range(0, 1));
    endfunction

    function automatic void put_name(int nlab, int maxlen);
        int len;
        for (int l = 0; l < nlab; l++) begin
            len = $urandom_range(1, maxlen);
            pkt.push_back(t_u8'(len));
            repeat (len) pkt.push_back(($urandom_range(0, 7) == 0) ? t_u8'($urandom)
                                       : t_u8'($urandom_range(8'h61, 8'h7A)));
        end
        pkt.push_back(8'h00);
    endfunction

    function automatic void put_ptr(int unsigned off);
        pkt.push_back(dnsrp_pkg::PTR_MASK | t_u8'(off >> 8));
        pkt.push_back(t_u8'(off));
    endfunction

    function automatic void put_question();
        if ($urandom_range(0, 3) == 0) put_ptr(dnsrp_pkg::HDR_LEN);
        else put_name($urandom_range(1, 3), 8);
        put16(dnsrp_pkg::TYPE_A);
        put16(dnsrp_pkg::CLASS_IN);
    endfunction

    // owner name, type, class, ttl; returns rdlength position
    function automatic int put_rr_head(logic [15:0] typ, logic [15:0] cls, logic [31:0] ttl);
        int p;
        if ($urandom_range(0, 2) != 0) put_ptr(dnsrp_pkg::HDR_LEN);
        else put_name($urandom_range(1, 2), 6);
        put16(typ);
        put16(cls);
        put16(ttl[31:16]);
        put16(ttl[15:0]);
        p = pkt.size();
        put16(0);
        return p;
    endfunction

    function automatic void fix_rdlen(int p);
        int unsigned n;
        n = pkt.size() - p - 2;
        pkt[p] = t_u8'(n >> 8);
        pkt[p + 1] = t_u8'(n);
    endfunction

    function automatic void put_rr(logic [15:0] typ, logic [15:0] cls, int name_labels,
                                   int label_max);
        int p;
        p = put_rr_head(typ, cls, $urandom);
        if (typ == dnsrp_pkg::TYPE_A) begin
            repeat (($urandom_range(0, 5) == 0) ? $urandom_range(0, 6) : 4)
                pkt.push_back(t_u8'($urandom));
        end else if (typ == dnsrp_pkg::TYPE_PTR || typ == dnsrp_pkg::TYPE_CNAME) begin
            if ($urandom_range(0, 3) == 0) begin
                put_name($urandom_range(0, 1), 5);
                void'(pkt.pop_back());
                put_ptr(dnsrp_pkg::HDR_LEN);
            end else begin
                put_name(name_labels, label_max);
            end
        end else begin
            repeat ($urandom_range(0, 6)) pkt.push_back(t_u8'($urandom));
        end
        fix_rdlen(p);
    endfunction

    function automatic logic [15:0] pick_type();
        case ($urandom_range(0, 4))
            0, 1: return dnsrp_pkg::TYPE_A;
            2:    return dnsrp_pkg::TYPE_CNAME;
            3:    return dnsrp_pkg::TYPE_PTR;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void build_random(logic [15:0] id);
        int qd, an;
        qd = $urandom_range(0, 2);
        an = $urandom_range(1, 3);
        put_hdr(($urandom_range(0, 15) == 0) ? 16'($urandom) : id,
                {($urandom_range(0, 15) != 0), 11'($urandom),
                 ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'd0},
                qd, ($urandom_range(0, 15) == 0) ? 0 : an);
        repeat (qd) put_question();
        repeat (an) put_rr(pick_type(),
                           ($urandom_range(0, 9) == 0) ? 16'($urandom) : dnsrp_pkg::CLASS_IN,
                           $urandom_range(1, 5), ($urandom_range(0, 4) == 0) ? 63 : 10);
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 10)) void'(pkt.pop_back());
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 8)) pkt.push_back(t_u8'($urandom));
    endfunction

    // test tasks
    task automatic test_header_checks();
        logic [15:0] id;
        id = 16'hFFFF;
        pkt = '{8'hFF, 8'h00, 8'h80};
        send_packet(1, id);
        put_hdr(id, 16'h0100, 0, 1);
        send_packet(1, id);
        put_hdr(16'h0000, 16'h8000, 0, 1);
        send_packet(1, id);
        put_hdr(id, 16'h800F, 0, 1);
        send_packet(1, id);
        put_hdr(id, 16'hFFF0, 1, 0);
        put_question();
        send_packet(1, id);
        put_hdr(16'h0000, 16'h8180, 0, 1);
        send_packet(1, 16'h0000);
        drain();
    endtask

    task automatic test_a_records();
        int p;
        put_hdr(16'hA5A5, 16'h8180, 1, 2);
        put_question();
        put_rr(dnsrp_pkg::TYPE_CNAME, dnsrp_pkg::CLASS_IN, 2, 5);
        p = put_rr_head(dnsrp_pkg::TYPE_A, dnsrp_pkg::CLASS_IN, 32'hFFFF_FFFF);
        put16(16'hFFFF);
        put16(16'hFFFF);
        fix_rdlen(p);
        send_packet(1, 16'hA5A5);
        put_hdr(16'h5A5A, 16'h8180, 0, 1);
        p = put_rr_head(dnsrp_pkg::TYPE_A, 16'd3, 32'h0);
        put16(0);
        put16(0);
        fix_rdlen(p);
        send_packet(1, 16'h5A5A);
        drain();
    endtask

    task automatic test_ptr_names();
        int p;
        put_hdr(16'h1234, 16'h8180, 1, 1);
        put_question();
        put_rr(dnsrp_pkg::TYPE_PTR, dnsrp_pkg::CLASS_IN, 3, 8);
        send_packet(1, 16'h1234);
        put_hdr(16'h1234, 16'h8180, 0, 1);
        put_rr(dnsrp_pkg::TYPE_PTR, dnsrp_pkg::CLASS_IN, 3, 63);
        send_packet(1, 16'h1234);
        // pointer loop on itself, unterminated name
        put_hdr(16'h1234, 16'h8180, 0, 1);
        p = put_rr_head(dnsrp_pkg::TYPE_PTR, dnsrp_pkg::CLASS_IN, $urandom);
        pkt.push_back(8'h02);
        pkt.push_back(8'h61);
        pkt.push_back(8'h62);
        put_ptr(pkt.size() - 3);
        fix_rdlen(p);
        send_packet(1, 16'h1234);
        // empty name
        put_hdr(16'h1234, 16'h8180, 0, 1);
        p = put_rr_head(dnsrp_pkg::TYPE_PTR, dnsrp_pkg::CLASS_IN, $urandom);
        pkt.push_back(8'h00);
        fix_rdlen(p);
        send_packet(1, 16'h1234);
        drain();
    endtask

    task automatic test_overflow();
        put_hdr(16'h0BAD, 16'h8180, 0, 2);
        put_rr(dnsrp_pkg::TYPE_CNAME, dnsrp_pkg::CLASS_IN, 1, 4);
        while (pkt.size() < dnsrp_pkg::BUF_BYTES + 8) pkt.push_back(t_u8'($urandom));
        send_packet(1, 16'h0BAD);
        drain();
    endtask

    task automatic test_random(int npkt);
        logic [15:0] id;
        for (int n = 0; n < npkt; n++) begin
            id = 16'($urandom);
            if ($urandom_range(0, 9) == 0) begin
                pkt.delete();
                repeat ($urandom_range(1, 40)) pkt.push_back(t_u8'($urandom));
            end else begin
                build_random(id);
            end
            send_packet($urandom_range(0, 7) != 0, id);
            if ($urandom_range(0, 19) == 0) drain();
        end
    endtask

    always @(posedge i_clk) begin
        t_answer e;
        if (i_rst_n && o_valid) begin
            if (answers_due.size() == 0) begin
                $error("unexpected result: kind %0h status %0h", o_item_kind, o_status);
                errors++;
            end else begin
                e = answers_due.pop_front();
                if (o_item_kind !== e.kind) begin
                    $error("item_kind exp %0h got %0h", e.kind, o_item_kind); errors++;
                end
                if (o_status !== e.status) begin
                    $error("status exp %0h got %0h", e.status, o_status); errors++;
                end
                if (o_rcode !== e.rcode) begin
                    $error("rcode exp %0h got %0h", e.rcode, o_rcode); errors++;
                end
                if (o_address !== e.addr) begin
                    $error("address exp %0h got %0h", e.addr, o_address); errors++;
                end
                if (o_ttl !== e.ttl) begin
                    $error("ttl exp %0h got %0h", e.ttl, o_ttl); errors++;
                end
                if (o_has_alias !== e.alias_f) begin
                    $error("has_alias exp %0h got %0h", e.alias_f, o_has_alias); errors++;
                end
                if (o_name_char !== e.ch) begin
                    $error("name_char exp %0h got %0h", e.ch, o_name_char); errors++;
                end
                if (o_last_item !== e.last) begin
                    $error("last_item exp %0h got %0h", e.last, o_last_item); errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_header_checks();
        test_a_records();
        test_ptr_names();
        test_overflow();
        test_random(2);
        quiet = 1'b1;
        test_random(2);
        drain();
        repeat (300) @(posedge i_clk);
        if (errors == 0 && answers_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            if (answers_due.size() != 0) $error("%0d results never arrived", answers_due.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
